@@ hw/rtl/kcrt_pkg.sv @@
// ----------------------------------------------------------------------------
// kcrt_pkg: shared types and constants of the keyed callback registry table
// Table depth, index widths, entry layout, action and status codes, and the
// control bundle between the sequencer and the entry store.
// ----------------------------------------------------------------------------
package kcrt_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  // wide enough for slot index plus two without wrapping
  localparam int unsigned NXT_W = CNT_W + 1;

  typedef enum logic [2:0] {
    ACT_REGISTER = 3'd0,
    ACT_ENABLE   = 3'd1,
    ACT_DISABLE  = 3'd2,
    ACT_DELETE   = 3'd3,
    ACT_DISPATCH = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]  etype;
    logic [31:0] hid;
    logic [31:0] addr;
    logic        on;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } store_req_t;

endpackage

@@ hw/rtl/kcrt_entry_store.sv @@
// ----------------------------------------------------------------------------
// kcrt_entry_store: entry memory with registered read and key compare
// One write port and one read port; the read entry is held in a register
// and compared against the lookup key of the current request.
// ----------------------------------------------------------------------------
module kcrt_entry_store (
  input  logic                clk_i,
  input  kcrt_pkg::store_req_t req_i,
  input  kcrt_pkg::entry_t     wr_entry_i,
  input  logic [7:0]          key_type_i,
  input  logic [31:0]         key_id_i,
  output kcrt_pkg::entry_t     rd_entry_o,
  output logic                match_o
);
  import kcrt_pkg::*;

  entry_t mem_q [MAX_ENTRIES];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_idx] <= wr_entry_i;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_idx];
    end
  end

  assign rd_entry_o = rd_q;
  assign match_o    = (rd_q.etype == key_type_i) && (rd_q.hid == key_id_i);

endmodule

@@ hw/rtl/keyed_callback_registry_table_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_callback_registry_table_unit: compacted table of keyed handlers
// Registers, enables, disables, deletes and dispatches handler entries.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_stall_o) carries one request per
// accepted beat: action, event type, handler id, handler address, event data.
// The output channel (out_valid_o / out_stall_i) returns exactly one result
// per request: status, call_valid, call_target, call_data.
// Each request runs through a sequencer that scans the table slot by slot,
// a read state then a compare state per slot, through a single memory read
// port and one key comparator. Register writes an accepted new entry at slot
// entry_count without a scan. Enable, disable, delete and dispatch scan from
// slot 0 until the key matches; delete then shifts each later entry down
// through the same port. A miss scans all entry_count slots. One request is
// in work at a time; in_stall_o is high while it runs.
// The result sits in an output register: a new request is taken while a
// result waits, and a stalled result holds until out_stall_i drops.
// Reset clears the entry count and all control state; table contents are
// left as they are and only slots below the count are ever read.
// ----------------------------------------------------------------------------
module keyed_callback_registry_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  event_type_i,
  input  logic [31:0] handler_id_i,
  input  logic [31:0] handler_address_i,
  input  logic [31:0] event_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        call_valid_o,
  output logic [31:0] call_target_o,
  output logic [31:0] call_data_o
);
  import kcrt_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_START    = 7'b0000010,
    ST_READ     = 7'b0000100,
    ST_CMP      = 7'b0001000,
    ST_SHIFT_RD = 7'b0010000,
    ST_SHIFT_WR = 7'b0100000,
    ST_RESP     = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;

  action_e     req_action_q;
  logic [7:0]  req_type_q;
  logic [31:0] req_id_q;
  logic [31:0] req_addr_q;
  logic [31:0] req_data_q;

  status_e     res_status_q, res_status_d;
  logic        res_call_q, res_call_d;
  logic [31:0] res_target_q, res_target_d;

  status_e     out_status_q;
  logic        out_call_q;
  logic [31:0] out_target_q;
  logic [31:0] out_data_q;

  logic             load_req;
  logic             out_load;
  logic [NXT_W-1:0] nxt_idx;
  logic [NXT_W-1:0] nxt2_idx;
  logic [NXT_W-1:0] count_ext;

  store_req_t store_req;
  entry_t     wr_entry;
  entry_t     rd_entry;
  logic       store_match;

  kcrt_entry_store u_store (
    .clk_i      (clk_i),
    .req_i      (store_req),
    .wr_entry_i (wr_entry),
    .key_type_i (req_type_q),
    .key_id_i   (req_id_q),
    .rd_entry_o (rd_entry),
    .match_o    (store_match)
  );

  assign nxt_idx   = NXT_W'(idx_q) + NXT_W'(1);
  assign nxt2_idx  = nxt_idx + NXT_W'(1);
  assign count_ext = NXT_W'(count_q);

  // memory port control
  always_comb begin
    store_req.wr_en  = 1'b0;
    store_req.wr_idx = idx_q;
    store_req.rd_en  = 1'b0;
    store_req.rd_idx = idx_q;
    wr_entry         = rd_entry;
    unique case (state_q)
      ST_START: begin
        if (req_action_q == ACT_REGISTER && req_addr_q != '0 &&
            count_q < CNT_W'(MAX_ENTRIES)) begin
          store_req.wr_en  = 1'b1;
          store_req.wr_idx = count_q[IDX_W-1:0];
          wr_entry.etype   = req_type_q;
          wr_entry.hid     = req_id_q;
          wr_entry.addr    = req_addr_q;
          wr_entry.on      = 1'b0;
        end
      end
      ST_READ: begin
        store_req.rd_en = 1'b1;
      end
      ST_CMP: begin
        if (store_match &&
            (req_action_q == ACT_ENABLE || req_action_q == ACT_DISABLE)) begin
          store_req.wr_en = 1'b1;
          wr_entry.on     = (req_action_q == ACT_ENABLE);
        end
      end
      ST_SHIFT_RD: begin
        store_req.rd_en  = 1'b1;
        store_req.rd_idx = nxt_idx[IDX_W-1:0];
      end
      ST_SHIFT_WR: begin
        store_req.wr_en = 1'b1;
      end
      ST_IDLE, ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_call_d   = res_call_q;
    res_target_d = res_target_q;
    load_req     = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          load_req = 1'b1;
          state_d  = ST_START;
        end
      end
      ST_START: begin
        idx_d        = '0;
        res_call_d   = 1'b0;
        res_target_d = '0;
        res_status_d = STATUS_INVALID;
        state_d      = ST_RESP;
        case (req_action_q) inside
          ACT_REGISTER: begin
            if (req_addr_q == '0) begin
              res_status_d = STATUS_INVALID;
            end else if (count_q >= CNT_W'(MAX_ENTRIES)) begin
              res_status_d = STATUS_FULL;
            end else begin
              res_status_d = STATUS_OK;
              count_d      = count_q + CNT_W'(1);
            end
          end
          ACT_ENABLE, ACT_DISABLE, ACT_DELETE, ACT_DISPATCH: begin
            if (count_q != '0) begin
              state_d = ST_READ;
            end
          end
          default: begin
          end
        endcase
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (store_match) begin
          res_status_d = STATUS_OK;
          state_d      = ST_RESP;
          if (req_action_q == ACT_DISPATCH && rd_entry.on) begin
            res_call_d   = 1'b1;
            res_target_d = rd_entry.addr;
          end
          if (req_action_q == ACT_DELETE) begin
            if (nxt_idx < count_ext) begin
              state_d = ST_SHIFT_RD;
            end else begin
              count_d = count_q - CNT_W'(1);
            end
          end
        end else if (nxt_idx < count_ext) begin
          idx_d   = IDX_W'(nxt_idx);
          state_d = ST_READ;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SHIFT_RD: begin
        state_d = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        // advance to the next slot to fill, or close the gap at the end
        idx_d = IDX_W'(nxt_idx);
        if (nxt2_idx < count_ext) begin
          state_d = ST_SHIFT_RD;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_req) begin
      req_action_q <= action_e'(action_i);
      req_type_q   <= event_type_i;
      req_id_q     <= handler_id_i;
      req_addr_q   <= handler_address_i;
      req_data_q   <= event_data_i;
    end
    res_status_q <= res_status_d;
    res_call_q   <= res_call_d;
    res_target_q <= res_target_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_call_q   <= res_call_q;
      out_target_q <= res_target_q;
      out_data_q   <= res_call_q ? req_data_q : 32'd0;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign call_valid_o  = out_call_q;
  assign call_target_o = out_target_q;
  assign call_data_o   = out_data_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_shift_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT_RD || state_q == ST_SHIFT_WR) |-> (nxt_idx < count_ext))
    else $error("compaction shift beyond valid entries");

  a_out_from_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result issued outside response state");

  a_call_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_call_q) |-> (out_status_q == STATUS_OK))
    else $error("call issued with non-ok status");

endmodule
